// ===== rtl/core/crc8f_pkg.sv =====
`default_nettype none
// ----------------------------------------------------------------------------
// crc8f_pkg
// Shared types, constants and the CRC-8 byte fold for the frame encoder.
// ----------------------------------------------------------------------------
package crc8f_pkg;

    localparam int unsigned BYTE_W   = 8;
    localparam int unsigned FILL_W   = 3;
    localparam int unsigned POS_W    = 3;
    localparam int unsigned APB_DW   = 32;
    localparam int unsigned APB_AW   = 3;

    localparam logic [BYTE_W-1:0] FRAME_MARK     = 8'h7E;
    localparam logic [BYTE_W-1:0] CRC8_GENERATOR = 8'h31;
    localparam logic [BYTE_W-1:0] CRC_INIT       = 8'hFF;
    localparam logic [BYTE_W-1:0] IDLE_BYTE      = 8'hFF;

    localparam logic [FILL_W-1:0] FILL_RESET = 3'd2;
    localparam logic [FILL_W-1:0] FILL_MIN   = 3'd1;
    localparam logic [FILL_W-1:0] FILL_MAX   = 3'd4;

    // Register index of the only configuration register.
    localparam logic [0:0] REG_FILL_COUNT = 1'b0;

    // Slot positions inside one burst of line bytes.
    localparam logic [POS_W-1:0] POS_OPEN  = 3'd0;
    localparam logic [POS_W-1:0] POS_DATA  = 3'd1;
    localparam logic [POS_W-1:0] POS_CRC   = 3'd2;
    localparam logic [POS_W-1:0] POS_CLOSE = 3'd3;

    // Everything the serializer needs to emit the bytes caused by one item.
    typedef struct packed {
        logic              open;
        logic [BYTE_W-1:0] data;
        logic [BYTE_W-1:0] crc;
        logic              last;
        logic [FILL_W-1:0] fills;
    } burst_t;

    // MSB-first CRC-8 over one byte, no reflection.
    function automatic logic [BYTE_W-1:0] crc8_fold(input logic [BYTE_W-1:0] crc,
                                                    input logic [BYTE_W-1:0] b);
        logic [BYTE_W-1:0] c;
        c = crc ^ b;
        for (int k = 0; k < BYTE_W; k++) begin
            if (c[BYTE_W-1]) begin
                c = {c[BYTE_W-2:0], 1'b0} ^ CRC8_GENERATOR;
            end else begin
                c = {c[BYTE_W-2:0], 1'b0};
            end
        end
        return c;
    endfunction

endpackage : crc8f_pkg
`default_nettype wire

// ===== rtl/core/crc8f_regs.sv =====
`default_nettype none
// ----------------------------------------------------------------------------
// crc8f_regs
// APB-style configuration register holding the idle fill count.
// ----------------------------------------------------------------------------
module crc8f_regs
    import crc8f_pkg::*;
(
    input  wire logic              aclk,
    input  wire logic              aresetn,
    input  wire logic              psel,
    input  wire logic              penable,
    input  wire logic              pwrite,
    input  wire logic [APB_AW-1:0] paddr,
    input  wire logic [APB_DW-1:0] pwdata,
    output logic      [APB_DW-1:0] prdata,
    output logic                   pready,
    output logic      [FILL_W-1:0] fill_count
);

    logic [FILL_W-1:0] fill_reg;
    logic [FILL_W-1:0] fill_next;
    logic              hit;

    assign hit    = (paddr[APB_AW-1] == REG_FILL_COUNT) && (paddr[1:0] == 2'b00);
    assign pready = 1'b1;

    always_comb begin
        fill_next = fill_reg;
        if (psel && penable && pwrite && hit) begin
            fill_next = pwdata[FILL_W-1:0];
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            fill_reg <= FILL_RESET;
        end else begin
            fill_reg <= fill_next;
        end
    end

    assign prdata     = hit ? {{(APB_DW-FILL_W){1'b0}}, fill_reg} : '0;
    assign fill_count = fill_reg;

endmodule : crc8f_regs
`default_nettype wire

// ===== rtl/core/crc8f_fold.sv =====
`default_nettype none
// ----------------------------------------------------------------------------
// crc8f_fold
// Frame state and running CRC; builds the burst description for one byte.
// ----------------------------------------------------------------------------
module crc8f_fold
    import crc8f_pkg::*;
(
    input  wire logic              aclk,
    input  wire logic              aresetn,
    input  wire logic              accept,
    input  wire logic [BYTE_W-1:0] payload_byte,
    input  wire logic              last_byte,
    input  wire logic [FILL_W-1:0] fill_count,
    output burst_t                 burst,
    output logic                   in_frame
);

    logic [BYTE_W-1:0] crc_reg;
    logic [BYTE_W-1:0] crc_next;
    logic              in_frame_reg;
    logic              in_frame_next;
    logic [BYTE_W-1:0] crc_fold;
    logic [FILL_W-1:0] fills;

    assign crc_fold = crc8_fold(crc_reg, payload_byte);

    // Out-of-range counts are clamped to the legal 1..4.
    always_comb begin
        priority if (fill_count < FILL_MIN) begin
            fills = FILL_MIN;
        end else if (fill_count > FILL_MAX) begin
            fills = FILL_MAX;
        end else begin
            fills = fill_count;
        end
    end

    always_comb begin
        crc_next      = crc_reg;
        in_frame_next = in_frame_reg;
        if (accept) begin
            crc_next      = last_byte ? CRC_INIT : crc_fold;
            in_frame_next = !last_byte;
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            crc_reg      <= CRC_INIT;
            in_frame_reg <= 1'b0;
        end else begin
            crc_reg      <= crc_next;
            in_frame_reg <= in_frame_next;
        end
    end

    assign burst.open  = !in_frame_reg;
    assign burst.data  = payload_byte;
    assign burst.crc   = crc_fold;
    assign burst.last  = last_byte;
    assign burst.fills = fills;
    assign in_frame    = in_frame_reg;

endmodule : crc8f_fold
`default_nettype wire

// ===== rtl/core/crc8f_serializer.sv =====
`default_nettype none
// ----------------------------------------------------------------------------
// crc8f_serializer
// Holds one burst and emits its line bytes, one per output handshake.
// ----------------------------------------------------------------------------
module crc8f_serializer
    import crc8f_pkg::*;
(
    input  wire logic              aclk,
    input  wire logic              aresetn,
    input  wire burst_t            burst,
    input  wire logic              load,
    output logic                   can_load,
    output logic                   m_valid,
    input  wire logic              m_ready,
    output logic      [BYTE_W-1:0] m_line_byte,
    output logic                   m_run_end
);

    burst_t           burst_reg;
    burst_t           burst_next;
    logic             valid_reg;
    logic             valid_next;
    logic [POS_W-1:0] pos_reg;
    logic [POS_W-1:0] pos_next;
    logic [POS_W-1:0] end_reg;
    logic [POS_W-1:0] end_next;
    logic             at_end;

    assign at_end   = (pos_reg == end_reg);
    assign can_load = !valid_reg || (m_ready && at_end);

    always_comb begin
        burst_next = burst_reg;
        valid_next = valid_reg;
        pos_next   = pos_reg;
        end_next   = end_reg;
        if (load) begin
            burst_next = burst;
            valid_next = 1'b1;
            pos_next   = burst.open ? POS_OPEN : POS_DATA;
            end_next   = burst.last ? (POS_CLOSE + burst.fills) : POS_DATA;
        end else if (valid_reg && m_ready) begin
            if (at_end) begin
                valid_next = 1'b0;
            end else begin
                pos_next = pos_reg + 1'b1;
            end
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            valid_reg <= 1'b0;
            pos_reg   <= POS_DATA;
            end_reg   <= POS_DATA;
        end else begin
            valid_reg <= valid_next;
            pos_reg   <= pos_next;
            end_reg   <= end_next;
        end
    end

    always_ff @(posedge aclk) begin
        burst_reg <= burst_next;
    end

    always_comb begin
        unique case (pos_reg)
            POS_OPEN:  m_line_byte = FRAME_MARK;
            POS_DATA:  m_line_byte = burst_reg.data;
            POS_CRC:   m_line_byte = burst_reg.crc;
            POS_CLOSE: m_line_byte = FRAME_MARK;
            default:   m_line_byte = IDLE_BYTE;
        endcase
    end

    assign m_valid   = valid_reg;
    assign m_run_end = at_end;

endmodule : crc8f_serializer
`default_nettype wire

// ===== rtl/core/crc8_frame_encoder.sv =====
`default_nettype none
// ----------------------------------------------------------------------------
// crc8_frame_encoder
// HDLC-style framer: opening boundary, payload bytes, CRC-8 trailer,
// closing boundary and idle fill bytes.
// ----------------------------------------------------------------------------
//
//  Channel   Direction  Handshake          Payload
//  -------   ---------  -----------------  ---------------------------------
//  s_        in         s_valid/s_ready    s_payload_byte[7:0], s_last_byte
//  m_        out        m_valid/m_ready    m_line_byte[7:0], m_run_end
//  APB       in/out     psel/penable       fill_count at address 0x0
//
//  An accepted byte is folded into the CRC in the same cycle and its whole
//  burst of line bytes is captured in the serializer's burst register.
//  The serializer then emits one line byte per cycle while m_ready is high,
//  so one item yields 1 to 8 line bytes: one byte in mid frame,
//  two when it opens a frame, and up to eight for a one-byte frame with the
//  largest fill count.
//  A new item is taken in the cycle in which the last byte of the previous
//  burst is handed over, so a stream of mid-frame bytes runs at one item
//  per cycle while m_ready is high.
//  Reset (synchronous, active low on aresetn) closes any open frame, sets
//  the CRC to 0xFF, sets the fill count to 2 and empties the output.
//  Stalls on m_ready hold the current byte and back-pressure s_ready.
//
// ----------------------------------------------------------------------------
module crc8_frame_encoder
    import crc8f_pkg::*;
(
    input  wire logic              aclk,
    input  wire logic              aresetn,
    // Input byte channel.
    input  wire logic              s_valid,
    output logic                   s_ready,
    input  wire logic [BYTE_W-1:0] s_payload_byte,
    input  wire logic              s_last_byte,
    // Line byte channel.
    output logic                   m_valid,
    input  wire logic              m_ready,
    output logic      [BYTE_W-1:0] m_line_byte,
    output logic                   m_run_end,
    // Configuration port.
    input  wire logic              psel,
    input  wire logic              penable,
    input  wire logic              pwrite,
    input  wire logic [APB_AW-1:0] paddr,
    input  wire logic [APB_DW-1:0] pwdata,
    output logic      [APB_DW-1:0] prdata,
    output logic                   pready
);

    logic [FILL_W-1:0] fill_count;
    logic              accept;
    logic              can_load;
    logic              in_frame;
    burst_t            burst;

    // The serializer frees its burst register exactly when it can take
    // the next item, so the input handshake follows it directly.
    assign s_ready = can_load;
    assign accept  = s_valid && s_ready;

    crc8f_regs u_regs (
        .aclk       (aclk),
        .aresetn    (aresetn),
        .psel       (psel),
        .penable    (penable),
        .pwrite     (pwrite),
        .paddr      (paddr),
        .pwdata     (pwdata),
        .prdata     (prdata),
        .pready     (pready),
        .fill_count (fill_count)
    );

    // Frame state and CRC update for the byte being accepted.
    crc8f_fold u_fold (
        .aclk         (aclk),
        .aresetn      (aresetn),
        .accept       (accept),
        .payload_byte (s_payload_byte),
        .last_byte    (s_last_byte),
        .fill_count   (fill_count),
        .burst        (burst),
        .in_frame     (in_frame)
    );

    // Burst register and byte sequencer toward the line.
    crc8f_serializer u_ser (
        .aclk        (aclk),
        .aresetn     (aresetn),
        .burst       (burst),
        .load        (accept),
        .can_load    (can_load),
        .m_valid     (m_valid),
        .m_ready     (m_ready),
        .m_line_byte (m_line_byte),
        .m_run_end   (m_run_end)
    );

`ifndef ASSERT_OFF
    // A stalled burst must block new items.
    a_stall_blocks_input: assert property (@(posedge aclk) disable iff (!aresetn)
        (m_valid && !m_ready) |-> !s_ready)
        else $error("input accepted while output stalled");

    // A byte handed over that is not the end of its run is followed by more.
    a_run_continues: assert property (@(posedge aclk) disable iff (!aresetn)
        (m_valid && m_ready && !m_run_end) |=> m_valid)
        else $error("burst ended before run end");

    // A last byte closes the frame; any other byte leaves it open.
    a_frame_close: assert property (@(posedge aclk) disable iff (!aresetn)
        (s_valid && s_ready) |=> (in_frame == !$past(s_last_byte)))
        else $error("frame state does not follow last byte");

    // An accepted item always produces output in the next cycle.
    a_item_emits: assert property (@(posedge aclk) disable iff (!aresetn)
        (s_valid && s_ready) |=> m_valid)
        else $error("accepted item produced no output");
`endif

endmodule : crc8_frame_encoder
`default_nettype wire
